// File: rtl/lfp_pkg.sv
// shared types, constants and helpers for the leapfrog step pipeline
`timescale 1ns / 1ps
package lfp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FracW  = 24;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned ProdW  = 2 * DataW;
  // radius squared sum: three terms of 2*DataW-FracW bits, plus growth
  localparam int unsigned SumW   = 2 * DataW - FracW + 2;
  localparam int unsigned RemW   = SumW + 1;
  localparam int unsigned NumW   = CfgW + DataW;
  localparam int unsigned QuoW   = DataW;
  localparam int unsigned NumHiW = NumW - QuoW;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegCircSpeedSq   = IdxW'(0);
  localparam logic [IdxW-1:0] RegInvFlattenSq  = IdxW'(1);
  localparam logic [IdxW-1:0] RegTimeStep      = IdxW'(2);

  localparam logic [CfgW-1:0] CircSpeedSqRst  = CfgW'(812014);
  localparam logic [CfgW-1:0] InvFlattenSqRst = CfgW'(20712612);
  localparam logic [CfgW-1:0] TimeStepRst     = CfgW'(167772);

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [ProdW-1:0] prod_t;

  localparam prod_t WordMax = (prod_t'(1) <<< (DataW - 1)) - prod_t'(1);
  localparam prod_t WordMin = -WordMax - prod_t'(1);

  typedef struct packed {
    word_t val;
    logic  clip;
  } sat_t;

  // data carried alongside the arithmetic
  typedef struct packed {
    logic [2:0][DataW-1:0] pos;
    logic [2:0][DataW-1:0] vel;
    logic                  clip;
    logic                  sing;
  } carry_t;

  // one divider stage for all three lanes
  typedef struct packed {
    carry_t                c;
    logic [DataW-1:0]      wz;
    logic [SumW-1:0]       rsq;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic [2:0][RemW-1:0]  rem;
    logic [2:0][QuoW-1:0]  quo;
    logic [2:0][QuoW-1:0]  lo;
  } div_t;

  function automatic prod_t ext(input word_t w);
    return prod_t'(w);
  endfunction

  // clip to the signed word range
  function automatic sat_t sat_w(input prod_t v);
    sat_t s;
    if (v > WordMax) begin
      s.val  = word_t'(WordMax);
      s.clip = 1'b1;
    end else if (v < WordMin) begin
      s.val  = word_t'(WordMin);
      s.clip = 1'b1;
    end else begin
      s.val  = word_t'(v);
      s.clip = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [DataW-1:0] mag(input word_t w);
    return w[DataW-1] ? (~w + DataW'(1)) : w;
  endfunction

  function automatic prod_t mul_cw(input logic [CfgW-1:0] c, input word_t w);
    return prod_t'($signed({1'b0, c})) * ext(w);
  endfunction

endpackage

// File: rtl/leapfrog_step_log_potential.sv
// top level: pipelined drift-kick-drift leapfrog step in a flattened log potential
`timescale 1ns / 1ps
// One particle (position, velocity; signed Q8.24) enters per cycle and passes
// through 44 register stages: 12 arithmetic stages plus a 32-stage
// restoring divider that computes the three acceleration quotients one bit
// per stage. Throughput is one particle per cycle; a stall on the output
// holds the whole pipeline in place. Configuration registers are written
// over a separate channel that is always ready; write them only while the
// pipeline is empty, as the stages read them as the item passes.
module leapfrog_step_log_potential (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lfp_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [lfp_pkg::DataW-1:0]   cfg_data_i,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic signed [lfp_pkg::DataW-1:0] pos_x_i,
  input  logic signed [lfp_pkg::DataW-1:0] pos_y_i,
  input  logic signed [lfp_pkg::DataW-1:0] pos_z_i,
  input  logic signed [lfp_pkg::DataW-1:0] vel_x_i,
  input  logic signed [lfp_pkg::DataW-1:0] vel_y_i,
  input  logic signed [lfp_pkg::DataW-1:0] vel_z_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [lfp_pkg::DataW-1:0] new_pos_x_o,
  output logic signed [lfp_pkg::DataW-1:0] new_pos_y_o,
  output logic signed [lfp_pkg::DataW-1:0] new_pos_z_o,
  output logic signed [lfp_pkg::DataW-1:0] new_vel_x_o,
  output logic signed [lfp_pkg::DataW-1:0] new_vel_y_o,
  output logic signed [lfp_pkg::DataW-1:0] new_vel_z_o,
  output logic                        singular_o,
  output logic                        saturated_o
);

  localparam int unsigned DW = lfp_pkg::DataW;
  localparam int unsigned FW = lfp_pkg::FracW;
  localparam int unsigned QW = lfp_pkg::QuoW;
  localparam int unsigned SW = lfp_pkg::SumW;
  localparam int unsigned RW = lfp_pkg::RemW;
  localparam int unsigned NW = lfp_pkg::NumW;

  // configuration registers
  logic [lfp_pkg::CfgW-1:0] css_q, ifs_q, dt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      css_q <= lfp_pkg::CircSpeedSqRst;
      ifs_q <= lfp_pkg::InvFlattenSqRst;
      dt_q  <= lfp_pkg::TimeStepRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lfp_pkg::RegCircSpeedSq:  css_q <= cfg_data_i[lfp_pkg::CfgW-1:0];
        lfp_pkg::RegInvFlattenSq: ifs_q <= cfg_data_i[lfp_pkg::CfgW-1:0];
        lfp_pkg::RegTimeStep:     dt_q  <= cfg_data_i[lfp_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the output is held
  logic adv;
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vi_q, vj_q, vk_q, vl_q, vm_q;
  logic [QW-1:0] dv_q;

  assign adv     = !(vm_q && stall_i);
  assign stall_o = !adv;

  // stage a: first drift products
  lfp_pkg::carry_t a_c_q;
  lfp_pkg::prod_t  a_p_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_c_q.pos  <= {pos_z_i, pos_y_i, pos_x_i};
      a_c_q.vel  <= {vel_z_i, vel_y_i, vel_x_i};
      a_c_q.clip <= 1'b0;
      a_c_q.sing <= 1'b0;
      a_p_q[0]   <= lfp_pkg::mul_cw(dt_q, vel_x_i);
      a_p_q[1]   <= lfp_pkg::mul_cw(dt_q, vel_y_i);
      a_p_q[2]   <= lfp_pkg::mul_cw(dt_q, vel_z_i);
    end
  end

  // stage b: half-step drift
  lfp_pkg::carry_t b_c_d, b_c_q;

  always_comb begin
    lfp_pkg::sat_t d, r;
    b_c_d = a_c_q;
    for (int i = 0; i < 3; i++) begin
      d = lfp_pkg::sat_w(a_p_q[i] >>> (FW + 1));
      r = lfp_pkg::sat_w(lfp_pkg::ext(lfp_pkg::word_t'(a_c_q.pos[i])) + lfp_pkg::ext(d.val));
      b_c_d.pos[i] = r.val;
      b_c_d.clip   = b_c_d.clip | d.clip | r.clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_c_q <= b_c_d;
    end
  end

  // stage c: flattened z product
  lfp_pkg::carry_t c_c_q;
  lfp_pkg::prod_t  c_p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_c_q <= b_c_q;
      c_p_q <= lfp_pkg::mul_cw(ifs_q, lfp_pkg::word_t'(b_c_q.pos[2]));
    end
  end

  // stage d: saturate w
  lfp_pkg::carry_t d_c_q;
  lfp_pkg::word_t  d_w_q;

  always_ff @(posedge clk_i) begin
    lfp_pkg::sat_t   w;
    lfp_pkg::carry_t nc;
    if (adv) begin
      w       = lfp_pkg::sat_w(c_p_q >>> FW);
      nc      = c_c_q;
      nc.clip = c_c_q.clip | w.clip;
      d_c_q   <= nc;
      d_w_q   <= w.val;
    end
  end

  // stage e: squares
  lfp_pkg::carry_t e_c_q;
  lfp_pkg::word_t  e_w_q;
  lfp_pkg::prod_t  e_sq_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_c_q    <= d_c_q;
      e_w_q    <= d_w_q;
      e_sq_q[0] <= lfp_pkg::ext(lfp_pkg::word_t'(d_c_q.pos[0]))
                 * lfp_pkg::ext(lfp_pkg::word_t'(d_c_q.pos[0]));
      e_sq_q[1] <= lfp_pkg::ext(lfp_pkg::word_t'(d_c_q.pos[1]))
                 * lfp_pkg::ext(lfp_pkg::word_t'(d_c_q.pos[1]));
      e_sq_q[2] <= lfp_pkg::ext(lfp_pkg::word_t'(d_c_q.pos[2])) * lfp_pkg::ext(d_w_q);
    end
  end

  // stage f: radius sum
  lfp_pkg::carry_t f_c_q;
  lfp_pkg::word_t  f_w_q;
  logic [SW-1:0]   f_s_q;

  always_ff @(posedge clk_i) begin
    logic [SW-1:0]   s;
    lfp_pkg::carry_t nc;
    if (adv) begin
      s = SW'(e_sq_q[0] >>> FW) + SW'(e_sq_q[1] >>> FW) + SW'(e_sq_q[2] >>> FW);
      nc      = e_c_q;
      nc.sing = (s == '0);
      f_c_q   <= nc;
      f_w_q   <= e_w_q;
      f_s_q   <= s;
    end
  end

  // stage g: acceleration numerators
  logic [2:0][NW-1:0] g_num;
  logic [2:0]         g_neg;
  lfp_pkg::div_t      div_d [QW+1];
  lfp_pkg::div_t      div_q [QW+1];

  always_comb begin
    lfp_pkg::word_t c [3];
    c[0] = lfp_pkg::word_t'(f_c_q.pos[0]);
    c[1] = lfp_pkg::word_t'(f_c_q.pos[1]);
    c[2] = f_w_q;
    for (int i = 0; i < 3; i++) begin
      g_num[i] = NW'(css_q) * NW'(lfp_pkg::mag(c[i]));
      g_neg[i] = (c[i] > 0);
    end
  end

  always_comb begin
    div_d[0].c   = f_c_q;
    div_d[0].wz  = f_w_q;
    div_d[0].rsq = f_s_q;
    div_d[0].neg = g_neg;
    for (int i = 0; i < 3; i++) begin
      div_d[0].ovf[i] = (SW'(g_num[i][NW-1:QW]) >= f_s_q);
      div_d[0].rem[i] = RW'(g_num[i][NW-1:QW]);
      div_d[0].quo[i] = '0;
      div_d[0].lo[i]  = g_num[i][QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_d[0];
    end
  end

  // divider: one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_comb begin
      logic [RW-1:0] sh;
      div_d[k] = div_q[k-1];
      for (int i = 0; i < 3; i++) begin
        sh = {div_q[k-1].rem[i][RW-2:0], div_q[k-1].lo[i][QW-1]};
        div_d[k].lo[i] = {div_q[k-1].lo[i][QW-2:0], 1'b0};
        if (sh >= RW'(div_q[k-1].rsq)) begin
          div_d[k].rem[i] = sh - RW'(div_q[k-1].rsq);
          div_d[k].quo[i] = {div_q[k-1].quo[i][QW-2:0], 1'b1};
        end else begin
          div_d[k].rem[i] = sh;
          div_d[k].quo[i] = {div_q[k-1].quo[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // stage i: signed, saturated acceleration
  lfp_pkg::carry_t i_c_q;
  lfp_pkg::word_t  i_a_q [3];

  always_ff @(posedge clk_i) begin
    lfp_pkg::prod_t  q;
    lfp_pkg::sat_t   a;
    logic            cl;
    lfp_pkg::carry_t nc;
    if (adv) begin
      cl = 1'b0;
      for (int i = 0; i < 3; i++) begin
        q = div_q[QW].ovf[i] ? (lfp_pkg::prod_t'(1) <<< DW)
                             : lfp_pkg::prod_t'({1'b0, div_q[QW].quo[i]});
        a = lfp_pkg::sat_w(div_q[QW].neg[i] ? -q : q);
        if (div_q[QW].c.sing) begin
          i_a_q[i] <= '0;
        end else begin
          i_a_q[i] <= a.val;
          cl = cl | a.clip;
        end
      end
      nc      = div_q[QW].c;
      nc.clip = div_q[QW].c.clip | cl;
      i_c_q   <= nc;
    end
  end

  // stage j: kick products
  lfp_pkg::carry_t j_c_q;
  lfp_pkg::prod_t  j_p_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j_c_q <= i_c_q;
      for (int i = 0; i < 3; i++) begin
        j_p_q[i] <= lfp_pkg::mul_cw(dt_q, i_a_q[i]);
      end
    end
  end

  // stage k: velocity kick
  lfp_pkg::carry_t k_c_q;

  always_ff @(posedge clk_i) begin
    lfp_pkg::sat_t   d, v;
    lfp_pkg::carry_t nc;
    if (adv) begin
      nc = j_c_q;
      for (int i = 0; i < 3; i++) begin
        d = lfp_pkg::sat_w(j_p_q[i] >>> FW);
        v = lfp_pkg::sat_w(lfp_pkg::ext(lfp_pkg::word_t'(j_c_q.vel[i])) + lfp_pkg::ext(d.val));
        nc.vel[i] = v.val;
        nc.clip   = nc.clip | d.clip | v.clip;
      end
      k_c_q <= nc;
    end
  end

  // stage l: second drift products
  lfp_pkg::carry_t l_c_q;
  lfp_pkg::prod_t  l_p_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_c_q <= k_c_q;
      for (int i = 0; i < 3; i++) begin
        l_p_q[i] <= lfp_pkg::mul_cw(dt_q, lfp_pkg::word_t'(k_c_q.vel[i]));
      end
    end
  end

  // stage m: second half-step drift, output register
  lfp_pkg::carry_t m_c_q;

  always_ff @(posedge clk_i) begin
    lfp_pkg::sat_t   d, p;
    lfp_pkg::carry_t nc;
    if (adv) begin
      nc = l_c_q;
      for (int i = 0; i < 3; i++) begin
        d = lfp_pkg::sat_w(l_p_q[i] >>> (FW + 1));
        p = lfp_pkg::sat_w(lfp_pkg::ext(lfp_pkg::word_t'(l_c_q.pos[i])) + lfp_pkg::ext(d.val));
        nc.pos[i] = p.val;
        nc.clip   = nc.clip | d.clip | p.clip;
      end
      m_c_q <= nc;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      dv_q <= '0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
      vk_q <= 1'b0;
      vl_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (adv) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      dv_q <= {dv_q[QW-2:0], vg_q};
      vi_q <= dv_q[QW-1];
      vj_q <= vi_q;
      vk_q <= vj_q;
      vl_q <= vk_q;
      vm_q <= vl_q;
    end
  end

  assign valid_o     = vm_q;
  assign new_pos_x_o = m_c_q.pos[0];
  assign new_pos_y_o = m_c_q.pos[1];
  assign new_pos_z_o = m_c_q.pos[2];
  assign new_vel_x_o = m_c_q.vel[0];
  assign new_vel_y_o = m_c_q.vel[1];
  assign new_vel_z_o = m_c_q.vel[2];
  assign singular_o  = m_c_q.sing;
  assign saturated_o = m_c_q.clip;

endmodule
